/* hdl/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LBRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lbrb: same-cycle check failed");

// next-cycle implication, checked outside reset
`define LBRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lbrb: next-cycle check failed");

`endif

/* hdl/lbrb_pkg.sv */
// shared types and constants of the line-aware byte ring buffer
`timescale 1ns / 1ps
`default_nettype none

package lbrb_pkg;

    localparam int unsigned FIELD_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_SPARE  = 2'd3
    } t_cmd;

    localparam logic [7:0] NEWLINE = 8'h0A;

    // requests from the sequencer to the newline tracker
    typedef struct packed {
        logic fetch;
        logic push;
        logic pop;
    } t_nl_ctrl;

endpackage

`default_nettype wire

/* hdl/line_aware_byte_ring_buffer_core.sv */
// top level of the line-aware byte ring buffer
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// byte ring buffer over a 2**$clog2(DEPTH)-entry store holding at most one
// byte fewer than that. each input beat pushes a byte, pops a byte or only
// asks for status, and produces exactly one output beat with the accepted
// flag, the popped byte, occupancy, free space, the length through the first
// held newline and a flag for a full buffer without any newline. a push into
// a full buffer and a pop from an empty one are dropped with accepted low.
// the byte store and the newline position queue are synchronous memories,
// read at acceptance; the update state uses their data once the output
// register can take the result. the next beat is taken while the previous
// result waits in the output register. newline positions live in their own
// queue, so the line length is the distance from the read point to the queue
// head, no scan. counts wider than eight bits show their low eight bits.

module line_aware_byte_ring_buffer_core
    import lbrb_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_data_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_accepted,
    output logic      [7:0] o_data_out,
    output logic      [7:0] o_occupancy,
    output logic      [7:0] o_free_space,
    output logic      [7:0] o_line_length,
    output logic            o_full_without_line
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned XW = AW + FIELD_W;
    localparam logic [AW-1:0] IDX_MASK = '1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // byte store, read data registered
    logic [7:0]    r_byte_mem [2**AW];
    logic [7:0]    r_byte_rdata;

    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] r_wr_idx;
    logic [1:0]    r_cmd;
    logic [7:0]    r_din;

    // output register
    logic          r_out_valid;
    logic          r_acc;
    logic [7:0]    r_dout;
    logic [7:0]    r_occ;
    logic [7:0]    r_free;
    logic [7:0]    r_len;
    logic          r_fwl;

    logic          in_fire;
    logic          exec_go;
    logic [AW-1:0] occ;
    logic          push_ok;
    logic          pop_ok;
    logic [AW-1:0] n_rd_idx;
    logic [AW-1:0] n_wr_idx;
    logic [AW-1:0] n_occ;
    logic [AW-1:0] n_len;
    logic [7:0]    n_dout;
    t_nl_ctrl      nl_ctrl;
    logic [AW-1:0] nl_count;
    logic [AW-1:0] nl_head_n;
    logic [AW-1:0] nl_count_n;
    logic [XW-1:0] occ_x;
    logic [XW-1:0] free_x;
    logic [XW-1:0] len_x;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    // the update waits until the output register can take the result
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // decode of the held beat against the current indexes
    always_comb begin
        occ     = r_wr_idx - r_rd_idx;
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        case (r_cmd)
            CMD_PUSH: push_ok = (occ != IDX_MASK);
            CMD_POP:  pop_ok  = (occ != '0);
            default: ;
        endcase
        n_wr_idx = r_wr_idx + AW'(push_ok);
        n_rd_idx = r_rd_idx + AW'(pop_ok);
        n_occ    = n_wr_idx - n_rd_idx;
        n_dout   = pop_ok ? r_byte_rdata : 8'h00;
    end

    always_comb begin
        nl_ctrl.fetch = in_fire;
        nl_ctrl.push  = exec_go && push_ok && (r_din == NEWLINE);
        nl_ctrl.pop   = exec_go && pop_ok && (r_byte_rdata == NEWLINE) && (nl_count != '0);
    end

    lbrb_nl_track #(
        .AW (AW)
    ) u_nl_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (nl_ctrl),
        .i_pos     (r_wr_idx),
        .o_count   (nl_count),
        .o_head_n  (nl_head_n),
        .o_count_n (nl_count_n)
    );

    // distance from the read point through the first held newline
    assign n_len  = (nl_count_n != '0) ? (nl_head_n - n_rd_idx + AW'(1)) : '0;

    assign occ_x  = XW'(n_occ);
    assign free_x = XW'(IDX_MASK - n_occ);
    assign len_x  = XW'(n_len);

    // byte store access
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte_rdata <= r_byte_mem[r_rd_idx];
        end
        if (exec_go && push_ok) begin
            r_byte_mem[r_wr_idx] <= r_din;
        end
    end

    // held beat and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_command;
            r_din <= i_data_in;
        end
        if (exec_go) begin
            r_acc  <= push_ok || pop_ok;
            r_dout <= n_dout;
            r_occ  <= occ_x[FIELD_W-1:0];
            r_free <= free_x[FIELD_W-1:0];
            r_len  <= len_x[FIELD_W-1:0];
            r_fwl  <= (n_occ == IDX_MASK) && (nl_count_n == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_rd_idx    <= n_rd_idx;
                r_wr_idx    <= n_wr_idx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_accepted          = r_acc;
    assign o_data_out          = r_dout;
    assign o_occupancy         = r_occ;
    assign o_free_space        = r_free;
    assign o_line_length       = r_len;
    assign o_full_without_line = r_fwl;

    // newlines held never outnumber bytes held
    `LBRB_ASSERT_IMPL(a_nl_le_occ, i_clk, i_rst_n, 1'b1, nl_count <= occ)
    // an accepted beat moves to the update cycle
    `LBRB_ASSERT_NEXT(a_fire_exec, i_clk, i_rst_n, in_fire, r_state == S_EXEC)
    // a full buffer without a newline reports no line
    `LBRB_ASSERT_IMPL(a_fwl_no_len, i_clk, i_rst_n, o_out_valid && o_full_without_line,
        o_line_length == 8'h00)
    // a finished update always leaves a result pending
    `LBRB_ASSERT_NEXT(a_exec_out, i_clk, i_rst_n, exec_go, o_out_valid)

endmodule

`default_nettype wire

/* hdl/lbrb_nl_track.sv */
// newline position queue with a cached head entry
`timescale 1ns / 1ps
`default_nettype none

module lbrb_nl_track
    import lbrb_pkg::*;
#(
    parameter int unsigned AW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_nl_ctrl      i_ctrl,
    input  wire logic [AW-1:0] i_pos,
    output logic      [AW-1:0] o_count,
    output logic      [AW-1:0] o_head_n,
    output logic      [AW-1:0] o_count_n
);

    logic [AW-1:0] r_pos_mem [2**AW];
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_count;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_next_head;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_count;

    // prefetch the entry behind the head so a pop can promote it
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fetch) begin
            r_next_head <= r_pos_mem[r_rd_ptr + AW'(1)];
        end
        if (i_ctrl.push) begin
            r_pos_mem[r_wr_ptr] <= i_pos;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + AW'(1);
            if (r_count == '0) begin
                n_head = i_pos;
            end
        end else if (i_ctrl.pop) begin
            n_count = r_count - AW'(1);
            n_head  = r_next_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

    assign o_count   = r_count;
    assign o_head_n  = n_head;
    assign o_count_n = n_count;

endmodule

`default_nettype wire
